// ===== rtl/ptcb_pkg.sv =====
// Package for the pretrigger capture buffer: payload structs, result kinds,
// operation codes, sequencer states and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package ptcb_pkg;

    localparam int REC_FIELD_W      = 64;
    localparam int EVT_W            = 32;
    localparam int RING_DEPTH_DEF   = 32;
    localparam int RECORD_WIDTH_DEF = 64;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    localparam logic [1:0] KIND_OPEN   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    typedef struct packed {
        logic                   op;
        logic [REC_FIELD_W-1:0] sample;
        logic                   in_event;
        logic [EVT_W-1:0]       event_number;
        logic                   sink_ready;
        logic                   open_ok;
    } t_in;

    typedef struct packed {
        logic [1:0]             kind;
        logic [REC_FIELD_W-1:0] record;
        logic [EVT_W-1:0]       event_id;
        logic                   last;
        logic                   capture_active;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DUMP,
        ST_CUR
    } t_state;

endpackage

// ===== rtl/ptcb_ring.sv =====
// Sample ring storage: one write port, one read port, registered read data.
// Depends on nothing; sized by the parameters handed down from the top level.
`timescale 1ns / 1ps

module ptcb_ring #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/pretrigger_capture_buffer.sv =====
// Top level of the pretrigger capture buffer: command port, capture sequencer
// and ring pointers. Depends on ptcb_pkg and ptcb_ring.
//
//  channel   signals                      transfer
//  -------   --------------------------   ------------------------------
//  input     start, busy, i_in (t_in)     edge with start=1 and busy=0
//  result    o_valid, o_result (t_out)    each cycle with o_valid=1
//
// A push never raises busy; pushes can follow back to back.
// A process item that yields results shows its first one in the cycle after the transfer. After
// a granted open, busy stays high until the current record is out: the ring dump is
// paced by the single read port, one record per cycle, then the current record.
// A refused open keeps busy high only for the current record (ST_CUR); other process items none.
// Synchronous active-low reset clears the write pointer, fill count and capture state;
// the ring contents stay undefined. Results cannot be stalled.
`timescale 1ns / 1ps

module pretrigger_capture_buffer #(
    parameter int RING_DEPTH   = ptcb_pkg::RING_DEPTH_DEF,
    parameter int RECORD_WIDTH = ptcb_pkg::RECORD_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ptcb_pkg::t_in  i_in,
    output logic           o_valid,
    output ptcb_pkg::t_out o_result
);

    import ptcb_pkg::*;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    t_state              r_state, n_state;
    t_out                r_out, n_out;
    logic                r_valid, n_valid;
    logic                r_active, n_active;
    logic [EVT_W-1:0]    r_evt, n_evt;
    logic [PTR_W-1:0]    r_wp, n_wp;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [FILL_W-1:0]   r_left, n_left;
    logic [PTR_W-1:0]    r_rd_addr, n_rd_addr;
    logic [RECORD_WIDTH-1:0] r_cur, n_cur;

    logic                    wr_en;
    logic                    rd_en;
    logic [RECORD_WIDTH-1:0] rd_data;
    logic [RECORD_WIDTH-1:0] sample_k;
    logic [FILL_W-1:0]       start_ext;
    logic [PTR_W-1:0]        start_addr;

    assign sample_k = i_in.sample[RECORD_WIDTH-1:0];

    // oldest entry; modular difference stays below the depth
    assign start_ext  = FILL_W'(r_wp) + FILL_W'(RING_DEPTH) - r_fill;
    assign start_addr = (FILL_W'(r_wp) >= r_fill) ? PTR_W'(FILL_W'(r_wp) - r_fill)
                                                  : start_ext[PTR_W-1:0];

    ptcb_ring #(
        .DEPTH (RING_DEPTH),
        .WIDTH (RECORD_WIDTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (sample_k),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_active <= 1'b0;
            r_evt    <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_active <= n_active;
            r_evt    <= n_evt;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_rd_addr <= n_rd_addr;
        r_cur     <= n_cur;
    end

    always_comb begin
        n_state   = r_state;
        n_out     = r_out;
        n_valid   = 1'b0;
        n_active  = r_active;
        n_evt     = r_evt;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_left    = r_left;
        n_rd_addr = r_rd_addr;
        n_cur     = r_cur;
        wr_en     = 1'b0;
        rd_en     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_in.op == OP_PUSH) begin
                        wr_en = 1'b1;
                        n_wp  = (r_wp == PTR_W'(RING_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
                        if (r_fill < FILL_W'(RING_DEPTH)) begin
                            n_fill = r_fill + FILL_W'(1);
                        end
                    end else if (i_in.in_event) begin
                        n_active = 1'b1;
                        n_out.capture_active = 1'b1;
                        n_out.kind   = KIND_RECORD;
                        n_out.record = REC_FIELD_W'(sample_k);
                        n_out.last   = 1'b1;
                        if (!r_active) begin
                            n_evt = i_in.event_number;
                        end
                        n_out.event_id = n_evt;
                        if (i_in.sink_ready) begin
                            n_valid = 1'b1;
                            if (!r_active) begin
                                // open goes first, current record trails
                                n_out.kind   = KIND_OPEN;
                                n_out.record = '0;
                                n_out.last   = 1'b0;
                                n_cur        = sample_k;
                                if (i_in.open_ok && r_fill != '0) begin
                                    rd_en     = 1'b1;
                                    n_rd_addr = start_addr;
                                    n_left    = r_fill;
                                    n_state   = ST_DUMP;
                                end else begin
                                    n_state = ST_CUR;
                                end
                            end
                        end
                    end else if (r_active) begin
                        n_active = 1'b0;
                        n_valid  = 1'b1;
                        n_out.kind           = KIND_CLOSE;
                        n_out.record         = '0;
                        n_out.event_id       = r_evt;
                        n_out.last           = 1'b1;
                        n_out.capture_active = 1'b0;
                    end
                end
            end
            ST_DUMP: begin
                n_valid      = 1'b1;
                n_out.kind   = KIND_RECORD;
                n_out.record = REC_FIELD_W'(rd_data);
                n_out.last   = 1'b0;
                n_left       = r_left - FILL_W'(1);
                if (r_left == FILL_W'(1)) begin
                    n_state = ST_CUR;
                end else begin
                    rd_en     = 1'b1;
                    n_rd_addr = (r_rd_addr == PTR_W'(RING_DEPTH - 1)) ? '0
                                                                      : r_rd_addr + PTR_W'(1);
                end
            end
            ST_CUR: begin
                n_valid      = 1'b1;
                n_out.kind   = KIND_RECORD;
                n_out.record = REC_FIELD_W'(r_cur);
                n_out.last   = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_open_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == KIND_OPEN |-> !o_result.last)
        else $error("open command flagged as last");

    a_active_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.capture_active == (o_result.kind != KIND_CLOSE))
        else $error("capture_active inconsistent with result kind");

    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DUMP |-> r_left != '0 && r_left <= r_fill)
        else $error("dump count out of range");

    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_wp) && $stable(r_fill))
        else $error("ring pointers moved during a dump");

    a_cur_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CUR |=> o_valid && o_result.last && o_result.kind == KIND_RECORD)
        else $error("current record missing after open");
`endif

endmodule

// ===== tb/sv/tb_pretrigger_capture_buffer.sv =====
// Self-checking testbench for pretrigger_capture_buffer: directed capture cases,
// then random push/trigger sequences under several sender idle rates.
// Depends on ptcb_pkg and the pretrigger_capture_buffer RTL.
`timescale 1ns / 1ps

module tb_pretrigger_capture_buffer;

    import ptcb_pkg::*;

    localparam int DEPTH      = RING_DEPTH_DEF;
    localparam int MAX_REPORT = 10;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_in   i_in    = '0;
    logic  o_valid;
    t_out  o_result;

    pretrigger_capture_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Mirror of the capture state
    logic [REC_FIELD_W-1:0] ring_mirror [DEPTH];
    logic [4:0]             mirror_wr_ptr;
    int                     mirror_fill;
    logic                   mirror_active;
    logic [EVT_W-1:0]       mirror_event;

    t_out pending_results[$];

    int idle_pct;
    int mismatches;
    int items_sent;
    int pushes_sent;
    int captures_started;
    int results_checked;
    int deepest_dump;

    // Computes what one accepted item should emit and queues it
    task automatic predict_capture(input t_in item);
        t_out       batch[$];
        t_out       res;
        logic [4:0] idx;
        begin
            if (item.op == OP_PUSH) begin
                ring_mirror[mirror_wr_ptr] = item.sample;
                mirror_wr_ptr = mirror_wr_ptr + 5'd1;
                if (mirror_fill < DEPTH)
                    mirror_fill++;
                pushes_sent++;
            end else if (item.in_event) begin
                if (!mirror_active) begin
                    mirror_active = 1'b1;
                    mirror_event  = item.event_number;
                    captures_started++;
                    if (item.sink_ready) begin
                        res = '0;
                        res.kind = KIND_OPEN;
                        batch.push_back(res);
                        if (item.open_ok) begin
                            // oldest entry first; a full ring starts at the write pointer
                            for (int i = 0; i < mirror_fill; i++) begin
                                idx = mirror_wr_ptr - 5'(mirror_fill) + 5'(i);
                                res = '0;
                                res.kind   = KIND_RECORD;
                                res.record = ring_mirror[idx];
                                batch.push_back(res);
                            end
                            if (mirror_fill > deepest_dump)
                                deepest_dump = mirror_fill;
                        end
                    end
                end
                if (item.sink_ready) begin
                    res = '0;
                    res.kind   = KIND_RECORD;
                    res.record = item.sample;
                    batch.push_back(res);
                end
            end else if (mirror_active) begin
                mirror_active = 1'b0;
                res = '0;
                res.kind = KIND_CLOSE;
                batch.push_back(res);
            end
            foreach (batch[k]) begin
                batch[k].event_id       = mirror_event;
                batch[k].capture_active = mirror_active;
                batch[k].last           = (k == batch.size() - 1);
                pending_results.push_back(batch[k]);
            end
        end
    endtask

    function automatic t_in make_item(input logic op, input logic [REC_FIELD_W-1:0] sample,
                                      input logic trig, input logic [EVT_W-1:0] evnum,
                                      input logic ready, input logic ok);
        t_in item;
        item.op           = op;
        item.sample       = sample;
        item.in_event     = trig;
        item.event_number = evnum;
        item.sink_ready   = ready;
        item.open_ok      = ok;
        return item;
    endfunction

    function automatic t_in random_item();
        t_in          item;
        logic [127:0] raw;
        raw  = {$urandom, $urandom, $urandom, $urandom};
        item = raw[$bits(t_in)-1:0];
        return item;
    endfunction

    // Holds start until the transfer, then maybe leaves a gap with junk on i_in
    task automatic send_item(input t_in item);
        begin
            i_in  <= item;
            start <= 1'b1;
            @(posedge i_clk);
            while (busy)
                @(posedge i_clk);
            predict_capture(item);
            items_sent++;
            if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                i_in  <= random_item();
                @(posedge i_clk);
                while ($urandom_range(0, 99) < idle_pct)
                    @(posedge i_clk);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name,
                         exp_val, act_val);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("%0t: unexpected result kind %0d record %h", $realtime,
                             o_result.kind, o_result.record);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("kind", 64'(want.kind), 64'(o_result.kind));
                check_field("record", 64'(want.record), 64'(o_result.record));
                check_field("event_id", 64'(want.event_id), 64'(o_result.event_id));
                check_field("last", 64'(want.last), 64'(o_result.last));
                check_field("capture_active", 64'(want.capture_active),
                            64'(o_result.capture_active));
            end
        end
    end

    task automatic test_empty_ring_capture();
        begin
            send_item(make_item(OP_PROCESS, '1, 1'b0, '1, 1'b1, 1'b1));  // low, idle
            send_item(make_item(OP_PROCESS, 64'h0123_4567_89ab_cdef, 1'b1, 32'h0000_0001,
                                1'b1, 1'b1));
            send_item(make_item(OP_PROCESS, '0, 1'b1, '0, 1'b1, 1'b0));
            send_item(make_item(OP_PROCESS, '1, 1'b0, '1, 1'b1, 1'b1));
        end
    endtask

    task automatic test_extreme_samples_sink_not_ready();
        begin
            send_item(make_item(OP_PUSH, '0, 1'b1, '1, 1'b1, 1'b1));
            send_item(make_item(OP_PUSH, '1, 1'b0, '0, 1'b0, 1'b0));
            send_item(make_item(OP_PUSH, {16{4'ha}}, 1'b1, 32'h5555_5555, 1'b0, 1'b1));
            send_item(make_item(OP_PUSH, {16{4'h5}}, 1'b0, 32'haaaa_aaaa, 1'b1, 1'b0));
            // rising trigger while the sink is away: no open, no dump
            send_item(make_item(OP_PROCESS, 64'h8000_0000_0000_0001, 1'b1, '1, 1'b0, 1'b1));
            send_item(make_item(OP_PROCESS, 64'h7fff_ffff_ffff_fffe, 1'b1, '0, 1'b0, 1'b1));
            send_item(make_item(OP_PROCESS, 64'hdead_beef_cafe_f00d, 1'b1, '0, 1'b1, 1'b0));
            send_item(make_item(OP_PROCESS, '0, 1'b0, '0, 1'b0, 1'b0));  // close, sink away
        end
    endtask

    task automatic test_open_refused();
        begin
            send_item(make_item(OP_PROCESS, '1, 1'b1, '0, 1'b1, 1'b0));
            send_item(make_item(OP_PROCESS, {32'h0, 32'hffff_ffff}, 1'b0, '1, 1'b1, 1'b1));
            // granted open dumps the four pushes above
            send_item(make_item(OP_PROCESS, {32'hffff_ffff, 32'h0}, 1'b1, 32'h8000_0000,
                                1'b1, 1'b1));
            send_item(make_item(OP_PROCESS, '0, 1'b0, '0, 1'b1, 1'b0));
        end
    endtask

    // Mostly push bursts followed by a full capture; the rest is random noise
    task automatic test_random_captures(input int pct, input int quota);
        int target;
        int n_push;
        logic [EVT_W-1:0] evnum;
        begin
            idle_pct = pct;
            target   = items_sent + quota;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 80) begin
                    n_push = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 40)
                                                           : $urandom_range(0, 8);
                    repeat (n_push) begin
                        t_in item;
                        item    = random_item();
                        item.op = OP_PUSH;
                        send_item(item);
                    end
                    evnum = $urandom;
                    send_item(make_item(OP_PROCESS, {$urandom, $urandom}, 1'b1, evnum,
                                        $urandom_range(0, 99) < 85,
                                        $urandom_range(0, 99) < 80));
                    repeat ($urandom_range(0, 4))
                        send_item(make_item(OP_PROCESS, {$urandom, $urandom}, 1'b1, $urandom,
                                            $urandom_range(0, 99) < 80, 1'($urandom)));
                    send_item(make_item(OP_PROCESS, {$urandom, $urandom}, 1'b0, $urandom,
                                        1'($urandom), 1'($urandom)));
                end else begin
                    send_item(random_item());
                end
            end
        end
    endtask

    initial begin
        mirror_wr_ptr    = '0;
        mirror_fill      = 0;
        mirror_active    = 1'b0;
        mirror_event     = '0;
        idle_pct         = 0;
        mismatches       = 0;
        items_sent       = 0;
        pushes_sent      = 0;
        captures_started = 0;
        results_checked  = 0;
        deepest_dump     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_ring_capture();
        test_extreme_samples_sink_not_ready();
        test_open_refused();
        test_random_captures(0, 140);
        test_random_captures(84, 140);
        test_random_captures(17, 140);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);

        if (pending_results.size() != 0)
            mismatches++;
        $display("Sent %0d items (%0d pushes, %0d captures), checked %0d results.",
                 items_sent, pushes_sent, captures_started, results_checked);
        $display("Deepest ring dump %0d records; %0d mismatches.", deepest_dump, mismatches);
        if (mismatches == 0)
            $display("tb_pretrigger_capture_buffer: PASS");
        else
            $display("tb_pretrigger_capture_buffer: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_pretrigger_capture_buffer: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ptcb_pkg.sv
rtl/ptcb_ring.sv
rtl/pretrigger_capture_buffer.sv
tb/sv/tb_pretrigger_capture_buffer.sv
